[src/ket_pkg.sv]
// ----------------------------------------------------------------------------
// ket_pkg
// Shared types and constants for the keyed entry table: sizes, request and
// status codes, sequencer states and the register map.
// ----------------------------------------------------------------------------
package ket_pkg;

    localparam int DEPTH     = 16;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int CNT_W     = 5;
    localparam int KEY_W     = 32;
    localparam int PL_W      = 64;
    localparam int ENTRY_W   = KEY_W + PL_W;
    localparam int CAP_W     = 5;
    localparam int APB_DW    = 32;
    localparam int PADDR_W   = 3;
    localparam int REG_IDX_W = 1;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(DEPTH);

    typedef logic signed [KEY_W-1:0] t_key;
    typedef logic [PL_W-1:0]         t_payload;
    typedef logic [CNT_W-1:0]        t_count;

    typedef enum logic [1:0] {
        REQ_ADD = 2'd0,
        REQ_DEL = 2'd1,
        REQ_GET = 2'd2,
        REQ_UPD = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_ADD_DUP  = 3'd2,
        ST_GET_MISS = 3'd3,
        ST_DEL_MISS = 3'd4,
        ST_UPD_MISS = 3'd5,
        ST_UPD_DUP  = 3'd6
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_SCAN   = 2'd1,
        S_SHIFT  = 2'd2,
        S_RESULT = 2'd3
    } t_state;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_CAPACITY = 1'b0
    } t_reg_idx;

endpackage

[src/ket_if.sv]
// ----------------------------------------------------------------------------
// ket_if
// Valid/ready channels of the keyed entry table: request and response.
// ----------------------------------------------------------------------------
interface ket_req_if;
    logic              valid;
    logic              ready;
    logic [1:0]        req_type;
    ket_pkg::t_key     key;
    ket_pkg::t_key     new_key;
    ket_pkg::t_payload payload;

    modport source (output valid, req_type, key, new_key, payload, input ready);
    modport sink   (input valid, req_type, key, new_key, payload, output ready);
endinterface

interface ket_rsp_if;
    logic              valid;
    logic              ready;
    logic [2:0]        status;
    ket_pkg::t_key     found_key;
    ket_pkg::t_payload found_payload;
    ket_pkg::t_count   count;

    modport source (output valid, status, found_key, found_payload, count, input ready);
    modport sink   (input valid, status, found_key, found_payload, count, output ready);
endinterface

[src/ket_cfg.sv]
// ----------------------------------------------------------------------------
// ket_cfg
// APB register slave holding the capacity limit of the table.
// ----------------------------------------------------------------------------
module ket_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ket_pkg::PADDR_W-1:0]         paddr,
    input  logic [ket_pkg::APB_DW-1:0]          pwdata,
    output logic [ket_pkg::APB_DW-1:0]          prdata,
    output logic                                pready,
    output logic [ket_pkg::CAP_W-1:0]           o_capacity
);

    logic [ket_pkg::CAP_W-1:0]     r_capacity;
    logic [ket_pkg::CAP_W-1:0]     n_capacity;
    ket_pkg::t_reg_idx             reg_idx;
    logic                          wr_en;

    // decode word index from the byte address
    assign reg_idx = ket_pkg::t_reg_idx'(paddr[ket_pkg::PADDR_W-1:2]);
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;

    // write decode
    always_comb begin
        n_capacity = r_capacity;
        if (wr_en) begin
            unique case (reg_idx)
                ket_pkg::REG_CAPACITY: n_capacity = pwdata[ket_pkg::CAP_W-1:0];
                default: ;
            endcase
        end
    end

    // read decode
    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            ket_pkg::REG_CAPACITY: prdata = ket_pkg::APB_DW'(r_capacity);
            default: prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= ket_pkg::CAP_RESET;
        end else begin
            r_capacity <= n_capacity;
        end
    end

    assign o_capacity = r_capacity;

endmodule

[src/keyed_entry_table.sv]
// ----------------------------------------------------------------------------
// keyed_entry_table
// Insertion-ordered key/payload table with linear search and an APB
// capacity register.
// ----------------------------------------------------------------------------
// Requests arrive on the i_req valid/ready channel (add, delete, get,
// update); each one produces exactly one transfer on o_rsp carrying a
// status code, the entry found by a get and the fill count afterwards.
// Entries live in one memory with a single registered read port and one
// write port. Every request scans slots 0 .. fill_count-1 through that read
// port; a delete then moves the later entries down one slot each cycle. The
// response turns valid in the same cycle as the block becomes ready for the
// next request.
// One request is in progress at a time; i_req.ready is high only while the
// sequencer is idle. The response sits in an output register, so the next
// request may be taken while o_rsp waits; if the receiver stalls, the next
// response is held back until the register drains.
// Reset empties the table (fill count zero) and sets capacity to 16; the
// memory itself is not cleared. Capacity is written through APB at byte
// address 0. The user must write it only while the block is idle; the
// block itself does not enforce this.
// ----------------------------------------------------------------------------
module keyed_entry_table (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    ket_req_if.sink                       i_req,
    ket_rsp_if.source                     o_rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ket_pkg::PADDR_W-1:0]   paddr,
    input  logic [ket_pkg::APB_DW-1:0]    pwdata,
    output logic [ket_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);

    localparam int ADDR_W  = ket_pkg::ADDR_W;
    localparam int CNT_W   = ket_pkg::CNT_W;
    localparam int ENTRY_W = ket_pkg::ENTRY_W;
    localparam int KEY_W   = ket_pkg::KEY_W;
    localparam int PL_W    = ket_pkg::PL_W;
    localparam int CAP_W   = ket_pkg::CAP_W;

    // entry memory
    logic [ENTRY_W-1:0] mem [ket_pkg::DEPTH];
    logic [ENTRY_W-1:0] r_rd_data;

    // memory port controls
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [ENTRY_W-1:0] mem_wdata;

    // sequencer
    ket_pkg::t_state    r_state,    n_state;
    ket_pkg::t_req      r_req,      n_req;
    ket_pkg::t_key      r_key,      n_key;
    ket_pkg::t_key      r_new_key,  n_new_key;
    ket_pkg::t_payload  r_payload,  n_payload;
    ket_pkg::t_count    r_fill,     n_fill;
    logic [CNT_W-1:0]   r_rd_addr,  n_rd_addr;
    logic               r_cmp_vld,  n_cmp_vld;
    logic [ADDR_W-1:0]  r_cmp_idx,  n_cmp_idx;
    logic               r_hit,      n_hit;
    logic [ADDR_W-1:0]  r_slot,     n_slot;
    ket_pkg::t_key      r_hit_key,  n_hit_key;
    ket_pkg::t_payload  r_hit_pl,   n_hit_pl;
    logic               r_clash,    n_clash;
    ket_pkg::t_status   r_status,   n_status;
    ket_pkg::t_key      r_res_key,  n_res_key;
    ket_pkg::t_payload  r_res_pl,   n_res_pl;

    // response register
    logic               r_out_vld,  n_out_vld;
    ket_pkg::t_status   r_out_st,   n_out_st;
    ket_pkg::t_key      r_out_key,  n_out_key;
    ket_pkg::t_payload  r_out_pl,   n_out_pl;
    ket_pkg::t_count    r_out_cnt,  n_out_cnt;

    logic [CAP_W-1:0]   capacity;
    logic [CAP_W-1:0]   cap_eff;
    logic               table_full;
    ket_pkg::t_key      cmp_key;
    ket_pkg::t_payload  cmp_pl;
    logic               req_xfer;
    logic               pass_done;

    ket_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_capacity (capacity)
    );

    // clamp capacity to the table depth
    assign cap_eff    = (capacity > CAP_W'(ket_pkg::DEPTH)) ? CAP_W'(ket_pkg::DEPTH)
                                                           : capacity;
    assign table_full = (CAP_W'(r_fill) >= cap_eff);

    assign cmp_key   = r_rd_data[ENTRY_W-1 -: KEY_W];
    assign cmp_pl    = r_rd_data[PL_W-1:0];
    assign req_xfer  = i_req.valid & i_req.ready;
    assign pass_done = (r_rd_addr >= r_fill) & ~r_cmp_vld;

    assign i_req.ready = (r_state == ket_pkg::S_IDLE);

    // next state and memory controls
    always_comb begin
        n_state   = r_state;
        n_req     = r_req;
        n_key     = r_key;
        n_new_key = r_new_key;
        n_payload = r_payload;
        n_fill    = r_fill;
        n_rd_addr = r_rd_addr;
        n_cmp_vld = 1'b0;
        n_cmp_idx = r_cmp_idx;
        n_hit     = r_hit;
        n_slot    = r_slot;
        n_hit_key = r_hit_key;
        n_hit_pl  = r_hit_pl;
        n_clash   = r_clash;
        n_status  = r_status;
        n_res_key = r_res_key;
        n_res_pl  = r_res_pl;
        n_out_vld = r_out_vld & ~o_rsp.ready;
        n_out_st  = r_out_st;
        n_out_key = r_out_key;
        n_out_pl  = r_out_pl;
        n_out_cnt = r_out_cnt;
        rd_en     = 1'b0;
        rd_addr   = r_rd_addr[ADDR_W-1:0];
        mem_we    = 1'b0;
        mem_waddr = r_slot;
        mem_wdata = {r_new_key, r_payload};

        unique case (r_state)
            ket_pkg::S_IDLE: begin
                // latch the request and start the search pass
                if (req_xfer) begin
                    n_req     = ket_pkg::t_req'(i_req.req_type);
                    n_key     = i_req.key;
                    n_new_key = i_req.new_key;
                    n_payload = i_req.payload;
                    n_rd_addr = '0;
                    n_hit     = 1'b0;
                    n_clash   = 1'b0;
                    n_state   = ket_pkg::S_SCAN;
                end
            end

            ket_pkg::S_SCAN: begin
                // issue one read per cycle over the filled slots
                if (r_rd_addr < r_fill) begin
                    rd_en     = 1'b1;
                    n_rd_addr = r_rd_addr + CNT_W'(1);
                    n_cmp_vld = 1'b1;
                    n_cmp_idx = r_rd_addr[ADDR_W-1:0];
                end
                // compare the returning entry, keep the first key hit
                if (r_cmp_vld) begin
                    if (cmp_key == r_key && !r_hit) begin
                        n_hit     = 1'b1;
                        n_slot    = r_cmp_idx;
                        n_hit_key = cmp_key;
                        n_hit_pl  = cmp_pl;
                    end
                    if (cmp_key == r_new_key && r_new_key != r_key) begin
                        n_clash = 1'b1;
                    end
                end
                // pass finished: decide and apply
                if (pass_done) begin
                    n_status  = ket_pkg::ST_OK;
                    n_res_key = '0;
                    n_res_pl  = '0;
                    n_state   = ket_pkg::S_RESULT;
                    unique case (r_req)
                        ket_pkg::REQ_ADD: begin
                            if (table_full) begin
                                n_status = ket_pkg::ST_FULL;
                            end else if (r_hit) begin
                                n_status = ket_pkg::ST_ADD_DUP;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = r_fill[ADDR_W-1:0];
                                mem_wdata = {r_key, r_payload};
                                n_fill    = r_fill + CNT_W'(1);
                            end
                        end
                        ket_pkg::REQ_DEL: begin
                            if (!r_hit) begin
                                n_status = ket_pkg::ST_DEL_MISS;
                            end else begin
                                n_rd_addr = CNT_W'(r_slot) + CNT_W'(1);
                                n_state   = ket_pkg::S_SHIFT;
                            end
                        end
                        ket_pkg::REQ_GET: begin
                            if (!r_hit) begin
                                n_status = ket_pkg::ST_GET_MISS;
                            end else begin
                                n_res_key = r_hit_key;
                                n_res_pl  = r_hit_pl;
                            end
                        end
                        ket_pkg::REQ_UPD: begin
                            if (!r_hit) begin
                                n_status = ket_pkg::ST_UPD_MISS;
                            end else if (r_clash) begin
                                n_status = ket_pkg::ST_UPD_DUP;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = r_slot;
                                mem_wdata = {r_new_key, r_payload};
                            end
                        end
                        default: ;
                    endcase
                end
            end

            ket_pkg::S_SHIFT: begin
                // read slot j, write the registered data back to slot j-1
                if (r_rd_addr < r_fill) begin
                    rd_en     = 1'b1;
                    n_rd_addr = r_rd_addr + CNT_W'(1);
                    n_cmp_vld = 1'b1;
                    n_cmp_idx = r_rd_addr[ADDR_W-1:0];
                end
                if (r_cmp_vld) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_cmp_idx - ADDR_W'(1);
                    mem_wdata = r_rd_data;
                end
                if (pass_done) begin
                    n_fill  = r_fill - CNT_W'(1);
                    n_state = ket_pkg::S_RESULT;
                end
            end

            ket_pkg::S_RESULT: begin
                // hand over to the response register once it is free
                if (!r_out_vld || o_rsp.ready) begin
                    n_out_vld = 1'b1;
                    n_out_st  = r_status;
                    n_out_key = r_res_key;
                    n_out_pl  = r_res_pl;
                    n_out_cnt = r_fill;
                    n_state   = ket_pkg::S_IDLE;
                end
            end

            default: n_state = ket_pkg::S_IDLE;
        endcase
    end

    // entry memory: one read port, one write port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ket_pkg::S_IDLE;
            r_fill    <= '0;
            r_cmp_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_fill    <= n_fill;
            r_cmp_vld <= n_cmp_vld;
            r_out_vld <= n_out_vld;
        end
    end

    // request, search and response payload
    always_ff @(posedge i_clk) begin
        r_req     <= n_req;
        r_key     <= n_key;
        r_new_key <= n_new_key;
        r_payload <= n_payload;
        r_rd_addr <= n_rd_addr;
        r_cmp_idx <= n_cmp_idx;
        r_hit     <= n_hit;
        r_slot    <= n_slot;
        r_hit_key <= n_hit_key;
        r_hit_pl  <= n_hit_pl;
        r_clash   <= n_clash;
        r_status  <= n_status;
        r_res_key <= n_res_key;
        r_res_pl  <= n_res_pl;
        r_out_st  <= n_out_st;
        r_out_key <= n_out_key;
        r_out_pl  <= n_out_pl;
        r_out_cnt <= n_out_cnt;
    end

    assign o_rsp.valid         = r_out_vld;
    assign o_rsp.status        = r_out_st;
    assign o_rsp.found_key     = r_out_key;
    assign o_rsp.found_payload = r_out_pl;
    assign o_rsp.count         = r_out_cnt;

endmodule

[dv/ket_table_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ket_table_checker
// Passive checker for the keyed entry table: watches the request, response
// and APB channels, keeps its own copy of the table and the capacity
// register, and compares every response transfer field by field with the
// oldest predicted result. Hands the failure count and the number of results
// still owed back to the testbench top.
// ----------------------------------------------------------------------------
module ket_table_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    ket_req_if                          i_req,
    ket_rsp_if                          i_rsp,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic                        pready,
    input  logic [ket_pkg::PADDR_W-1:0] paddr,
    input  logic [ket_pkg::APB_DW-1:0]  pwdata,
    output int                          o_errors,
    output int                          o_pending
);

    localparam logic [ket_pkg::PADDR_W-1:0] CAP_ADDR =
        ket_pkg::PADDR_W'(4 * ket_pkg::REG_CAPACITY);

    typedef struct packed {
        ket_pkg::t_status  status;
        ket_pkg::t_key     found_key;
        ket_pkg::t_payload found_payload;
        ket_pkg::t_count   count;
    } t_table_result;

    // Shadow copy of the table and its capacity register
    ket_pkg::t_key             shadow_keys [ket_pkg::DEPTH];
    ket_pkg::t_payload         shadow_data [ket_pkg::DEPTH];
    int                        shadow_fill;
    logic [ket_pkg::CAP_W-1:0] shadow_cap;

    t_table_result    owed_results [$];
    int               fail_cnt;

    // First slot holding the key, or -1 when absent
    function automatic int find_key(ket_pkg::t_key k);
        for (int i = 0; i < shadow_fill; i++) begin
            if (shadow_keys[i] == k) return i;
        end
        return -1;
    endfunction

    // Apply one request to the shadow table and return the result it gives
    function automatic t_table_result apply_request(ket_pkg::t_req op, ket_pkg::t_key k,
                                                    ket_pkg::t_key nk,
                                                    ket_pkg::t_payload pl);
        t_table_result r;
        int            slot;
        int            eff_cap;
        bit            clash;
        r.status        = ket_pkg::ST_OK;
        r.found_key     = '0;
        r.found_payload = '0;
        eff_cap = (int'(shadow_cap) > ket_pkg::DEPTH) ? ket_pkg::DEPTH : int'(shadow_cap);
        case (op)
            ket_pkg::REQ_ADD: begin
                // full wins over the duplicate check
                if (shadow_fill >= eff_cap) begin
                    r.status = ket_pkg::ST_FULL;
                end else if (find_key(k) >= 0) begin
                    r.status = ket_pkg::ST_ADD_DUP;
                end else begin
                    shadow_keys[shadow_fill] = k;
                    shadow_data[shadow_fill] = pl;
                    shadow_fill++;
                end
            end
            ket_pkg::REQ_DEL: begin
                slot = find_key(k);
                if (slot < 0) begin
                    r.status = ket_pkg::ST_DEL_MISS;
                end else begin
                    // close the gap
                    for (int i = slot; i < shadow_fill - 1; i++) begin
                        shadow_keys[i] = shadow_keys[i+1];
                        shadow_data[i] = shadow_data[i+1];
                    end
                    shadow_fill--;
                end
            end
            ket_pkg::REQ_GET: begin
                slot = find_key(k);
                if (slot < 0) begin
                    r.status = ket_pkg::ST_GET_MISS;
                end else begin
                    r.found_key     = shadow_keys[slot];
                    r.found_payload = shadow_data[slot];
                end
            end
            default: begin
                slot  = find_key(k);
                clash = 1'b0;
                if (slot < 0) begin
                    r.status = ket_pkg::ST_UPD_MISS;
                end else begin
                    // a new key equal to the old one never clashes
                    if (nk != k) begin
                        for (int i = 0; i < shadow_fill; i++) begin
                            if (i != slot && shadow_keys[i] == nk) clash = 1'b1;
                        end
                    end
                    if (clash) begin
                        r.status = ket_pkg::ST_UPD_DUP;
                    end else begin
                        shadow_keys[slot] = nk;
                        shadow_data[slot] = pl;
                    end
                end
            end
        endcase
        r.count = ket_pkg::t_count'(shadow_fill);
        return r;
    endfunction

    // Check response transfers, predict request transfers, track APB writes
    always @(posedge i_clk) begin : watch
        t_table_result want;
        if (!i_rst_n) begin
            shadow_fill = 0;
            shadow_cap  = ket_pkg::CAP_RESET;
            owed_results.delete();
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                if (owed_results.size() == 0) begin
                    $display("%0t: response with no request outstanding: status %0d count %0d",
                             $time, i_rsp.status, i_rsp.count);
                    fail_cnt++;
                end else begin
                    want = owed_results.pop_front();
                    if (i_rsp.status !== want.status) begin
                        $display("%0t: status mismatch: expected %0d, actual %0d",
                                 $time, want.status, i_rsp.status);
                        fail_cnt++;
                    end
                    if (i_rsp.found_key !== want.found_key) begin
                        $display("%0t: found_key mismatch: expected %h, actual %h",
                                 $time, want.found_key, i_rsp.found_key);
                        fail_cnt++;
                    end
                    if (i_rsp.found_payload !== want.found_payload) begin
                        $display("%0t: found_payload mismatch: expected %h, actual %h",
                                 $time, want.found_payload, i_rsp.found_payload);
                        fail_cnt++;
                    end
                    if (i_rsp.count !== want.count) begin
                        $display("%0t: count mismatch: expected %0d, actual %0d",
                                 $time, want.count, i_rsp.count);
                        fail_cnt++;
                    end
                end
            end
            if (i_req.valid && i_req.ready) begin
                owed_results.push_back(apply_request(ket_pkg::t_req'(i_req.req_type),
                                                     i_req.key, i_req.new_key,
                                                     i_req.payload));
            end
            if (psel && penable && pwrite && pready && paddr == CAP_ADDR) begin
                shadow_cap = pwdata[ket_pkg::CAP_W-1:0];
            end
        end
        o_errors  <= fail_cnt;
        o_pending <= owed_results.size();
    end

endmodule

[dv/tb_keyed_entry_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_keyed_entry_table
// Stimulus and verdict for the keyed entry table.
// Runs a directed pass over misses, duplicates, in-place updates, deletes
// with shifting and the full-table cases at low capacities, then random
// phases at a range of capacities with keys drawn mostly from a small pool
// so that requests hit stored entries. Both channels idle at random, with
// stretches of back-to-back transfers. Prediction and checking live in
// ket_table_checker.
// ----------------------------------------------------------------------------
module tb_keyed_entry_table;

    localparam int                 WATCHDOG_LIMIT = 2000;
    localparam int                 DRAIN_CYCLES   = 50;
    localparam int                 PHASE_ITEMS    = 195;
    localparam int                 POOL_SIZE      = 24;
    localparam logic [ket_pkg::PADDR_W-1:0] CAP_ADDR =
        ket_pkg::PADDR_W'(4 * ket_pkg::REG_CAPACITY);
    localparam ket_pkg::t_key      KEY_MIN        = 32'sh8000_0000;
    localparam ket_pkg::t_key      KEY_MAX        = 32'sh7fff_ffff;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [ket_pkg::PADDR_W-1:0]  paddr;
    logic [ket_pkg::APB_DW-1:0]   pwdata;
    logic [ket_pkg::APB_DW-1:0]   prdata;
    logic                         pready;

    int                  error_cnt;
    int                  owed_cnt;
    bit                  back_to_back;
    ket_pkg::t_key       key_pool [POOL_SIZE];

    ket_req_if req_ch ();
    ket_rsp_if rsp_ch ();

    keyed_entry_table dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    ket_table_checker checker_inst (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (req_ch),
        .i_rsp     (rsp_ch),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .pready    (pready),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .o_errors  (error_cnt),
        .o_pending (owed_cnt)
    );

    // 100 MHz clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int draw_gap();
        return back_to_back ? 0 : int'($urandom_range(0, 17));
    endfunction

    // Present one request and hold it until the transfer
    task automatic send_request(ket_pkg::t_req op, ket_pkg::t_key k, ket_pkg::t_key nk,
                                ket_pkg::t_payload pl);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= op;
        req_ch.key      <= k;
        req_ch.new_key  <= nk;
        req_ch.payload  <= pl;
        do @(posedge i_clk); while (!req_ch.ready);
        @(negedge i_clk);
    endtask

    // Drop valid and hold until every owed response has arrived
    task automatic drain_responses();
        req_ch.valid <= 1'b0;
        while (owed_cnt != 0) @(negedge i_clk);
    endtask

    // APB write of the capacity register, only with the block idle
    task automatic write_capacity(logic [ket_pkg::CAP_W-1:0] cap);
        drain_responses();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CAP_ADDR;
        pwdata  <= ket_pkg::APB_DW'(cap);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic ket_pkg::t_payload rand_payload();
        return {$urandom, $urandom};
    endfunction

    // Mostly pool keys so requests find stored entries
    function automatic ket_pkg::t_key pick_key();
        if ($urandom_range(0, 99) < 85) return key_pool[$urandom_range(0, POOL_SIZE-1)];
        return ket_pkg::t_key'($urandom);
    endfunction

    task automatic refresh_pool();
        key_pool[0] = KEY_MIN;
        key_pool[1] = KEY_MAX;
        key_pool[2] = '0;
        key_pool[3] = '1;
        for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = ket_pkg::t_key'($urandom);
    endtask

    task automatic random_phase(int n_items);
        int            roll;
        ket_pkg::t_req op;
        ket_pkg::t_key k;
        ket_pkg::t_key nk;
        refresh_pool();
        for (int i = 0; i < n_items; i++) begin
            // switch between idling and back-to-back stretches now and then
            if ($urandom_range(0, 99) < 3) back_to_back = !back_to_back;
            roll = $urandom_range(0, 99);
            if (roll < 35)      op = ket_pkg::REQ_ADD;
            else if (roll < 55) op = ket_pkg::REQ_DEL;
            else if (roll < 80) op = ket_pkg::REQ_GET;
            else                op = ket_pkg::REQ_UPD;
            k    = pick_key();
            roll = $urandom_range(0, 99);
            if (roll < 30)      nk = k;
            else if (roll < 85) nk = key_pool[$urandom_range(0, POOL_SIZE-1)];
            else                nk = ket_pkg::t_key'($urandom);
            send_request(op, k, nk, rand_payload());
        end
    endtask

    // Response side: stall a random number of cycles before each transfer
    initial begin : receiver
        int gap;
        rsp_ch.ready = 1'b0;
        @(negedge i_clk);
        forever begin
            gap = draw_gap();
            if (gap > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!rsp_ch.valid);
            @(negedge i_clk);
        end
    end

    // End the run when no transfer of any kind happens for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
                    || (psel && penable) || !i_rst_n)
                quiet = 0;
            else
                quiet++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin : stimulus
        logic [ket_pkg::CAP_W-1:0] phase_caps [9];
        i_rst_n         = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        req_ch.valid    = 1'b0;
        req_ch.req_type = ket_pkg::REQ_ADD;
        req_ch.key      = '0;
        req_ch.new_key  = '0;
        req_ch.payload  = '0;
        back_to_back    = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // misses on the empty table
        send_request(ket_pkg::REQ_GET, KEY_MIN, '0, '0);
        send_request(ket_pkg::REQ_DEL, KEY_MIN, '0, '0);
        send_request(ket_pkg::REQ_UPD, KEY_MIN, KEY_MAX, '1);
        // fill, duplicate add, lookups
        send_request(ket_pkg::REQ_ADD, KEY_MIN, '0, '1);
        send_request(ket_pkg::REQ_ADD, KEY_MAX, '1, '0);
        send_request(ket_pkg::REQ_ADD, KEY_MIN, '0, 64'h1234_5678_9abc_def0);
        send_request(ket_pkg::REQ_GET, KEY_MIN, '0, '0);
        send_request(ket_pkg::REQ_GET, KEY_MAX, '0, '0);
        // update in place, update onto a held key, update to a fresh key
        send_request(ket_pkg::REQ_UPD, KEY_MIN, KEY_MIN, 64'h5555_5555_5555_5555);
        send_request(ket_pkg::REQ_UPD, KEY_MIN, KEY_MAX, '0);
        send_request(ket_pkg::REQ_UPD, KEY_MIN, '0, 64'haaaa_aaaa_aaaa_aaaa);
        send_request(ket_pkg::REQ_ADD, '1, '0, 64'h8000_0000_0000_0001);
        // delete the first entry so the rest shift down
        send_request(ket_pkg::REQ_DEL, '0, '0, '0);
        send_request(ket_pkg::REQ_GET, '1, '0, '0);
        send_request(ket_pkg::REQ_GET, KEY_MAX, '0, '0);
        // capacity at the fill count: full, and full ahead of a duplicate
        write_capacity(5'd2);
        send_request(ket_pkg::REQ_ADD, 32'sd5, '0, '1);
        send_request(ket_pkg::REQ_ADD, KEY_MAX, '0, '1);
        // capacity below the fill count: entries stay, adds refused
        write_capacity(5'd1);
        send_request(ket_pkg::REQ_ADD, 32'sd7, '0, '1);
        send_request(ket_pkg::REQ_DEL, KEY_MAX, '0, '0);
        send_request(ket_pkg::REQ_ADD, 32'sd7, '0, '1);
        // capacity zero: every add is full
        write_capacity(5'd0);
        send_request(ket_pkg::REQ_DEL, '1, '0, '0);
        send_request(ket_pkg::REQ_ADD, 32'sd3, '0, '1);

        // random phases across the capacity range, extremes included
        phase_caps = '{5'd16, 5'd31, 5'd1, 5'd0, 5'd17, 5'd8, 5'd2, 5'd16, 5'd16};
        phase_caps[7] = ket_pkg::CAP_W'($urandom_range(0, 31));
        for (int p = 0; p < 9; p++) begin
            write_capacity(phase_caps[p]);
            random_phase(PHASE_ITEMS);
        end

        drain_responses();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (error_cnt == 0 && owed_cnt == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
